/* hdl/brfee_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brfee_pkg: shared types and constants of the banked register file
// Beat formats, command codes, mode codes and exception vector tables.
// ---------------------------------------------------------------------------
package brfee_pkg;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  reg_index;
    logic [31:0] write_value;
    logic [2:0]  exception_kind;
    logic        irq_request;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        exception_taken;
    logic [31:0] pc_value;
    logic [4:0]  mode_now;
    logic        error_flag;
  } result_t;

  // Command codes.
  localparam logic [2:0] CMD_READ       = 3'd0;
  localparam logic [2:0] CMD_WRITE      = 3'd1;
  localparam logic [2:0] CMD_USER_READ  = 3'd2;
  localparam logic [2:0] CMD_USER_WRITE = 3'd3;
  localparam logic [2:0] CMD_EXCEPTION  = 3'd4;
  localparam logic [2:0] CMD_FIQ_SET    = 3'd5;
  localparam logic [2:0] CMD_INT_CHECK  = 3'd6;

  // Register indexes beyond the general registers.
  localparam logic [4:0] IDX_CPSR     = 5'd16;
  localparam logic [4:0] IDX_SPSR     = 5'd17;
  localparam logic [4:0] IDX_LAST_GPR = 5'd15;

  // Exception kinds.
  localparam logic [2:0] EXC_RESET   = 3'd0;
  localparam logic [2:0] EXC_UNDEF   = 3'd1;
  localparam logic [2:0] EXC_SWI     = 3'd2;
  localparam logic [2:0] EXC_PABT    = 3'd3;
  localparam logic [2:0] EXC_DABT    = 3'd4;
  localparam logic [2:0] EXC_IRQ     = 3'd5;
  localparam logic [2:0] EXC_FIQ     = 3'd6;
  localparam logic [2:0] EXC_INVALID = 3'd7;

  // Mode codes.
  localparam logic [4:0] PM_USER = 5'h10;
  localparam logic [4:0] PM_FIQ  = 5'h11;
  localparam logic [4:0] PM_IRQ  = 5'h12;
  localparam logic [4:0] PM_SVC  = 5'h13;
  localparam logic [4:0] PM_ABT  = 5'h17;
  localparam logic [4:0] PM_UND  = 5'h1B;

  // Status word bit positions and reset value.
  localparam int          BIT_I      = 7;
  localparam int          BIT_F      = 6;
  localparam logic [31:0] CPSR_RESET = 32'h0000_00D3;
  localparam logic [31:0] LR_OFFSET  = 32'd4;

  // Saved status slots; slots SVC..UND also select the R13/R14 bank.
  localparam logic [2:0] SLOT_FIQ  = 3'd0;
  localparam logic [2:0] SLOT_SVC  = 3'd1;
  localparam logic [2:0] SLOT_ABT  = 3'd2;
  localparam logic [2:0] SLOT_IRQ  = 3'd3;
  localparam logic [2:0] SLOT_UND  = 3'd4;
  localparam logic [2:0] SLOT_NONE = 3'd5;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load_item;
    logic execute;
  } ctl_t;

  function automatic logic [2:0] status_slot(input logic [4:0] mode);
    logic [2:0] slot;
    unique case (mode)
      PM_FIQ:  slot = SLOT_FIQ;
      PM_SVC:  slot = SLOT_SVC;
      PM_ABT:  slot = SLOT_ABT;
      PM_IRQ:  slot = SLOT_IRQ;
      PM_UND:  slot = SLOT_UND;
      default: slot = SLOT_NONE;
    endcase
    return slot;
  endfunction

  function automatic logic [31:0] vector_addr(input logic [2:0] kind);
    logic [31:0] addr;
    unique case (kind)
      EXC_RESET: addr = 32'h00;
      EXC_UNDEF: addr = 32'h04;
      EXC_SWI:   addr = 32'h08;
      EXC_PABT:  addr = 32'h0C;
      EXC_DABT:  addr = 32'h10;
      EXC_IRQ:   addr = 32'h18;
      default:   addr = 32'h1C;
    endcase
    return addr;
  endfunction

  function automatic logic [4:0] vector_mode(input logic [2:0] kind);
    logic [4:0] mode;
    unique case (kind)
      EXC_RESET: mode = PM_SVC;
      EXC_UNDEF: mode = PM_UND;
      EXC_SWI:   mode = PM_SVC;
      EXC_PABT:  mode = PM_ABT;
      EXC_DABT:  mode = PM_ABT;
      EXC_IRQ:   mode = PM_IRQ;
      default:   mode = PM_FIQ;
    endcase
    return mode;
  endfunction

endpackage

/* hdl/brfee_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brfee_ctrl: beat sequencer
// Takes one beat, executes it in the datapath and tracks the result beat.
// ---------------------------------------------------------------------------
module brfee_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              result_valid,
  input  logic              result_ready,
  output brfee_pkg::ctl_t   ctl
);
  import brfee_pkg::*;

  state_t state;
  state_t state_next;
  logic   result_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  always_comb begin
    state_next        = state;
    result_valid_next = result_valid && !result_ready;
    item_ready        = 1'b0;
    ctl               = '0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          ctl.load_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The output register must be free, or be emptied on this edge.
        if (!result_valid || result_ready) begin
          ctl.execute       = 1'b1;
          result_valid_next = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

/* hdl/brfee_datapath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// brfee_datapath: banked registers, status words and exception entry
// Holds the architectural state and applies one command per execute strobe.
// ---------------------------------------------------------------------------
module brfee_datapath (
  input  logic                clk,
  input  logic                rst,
  input  brfee_pkg::ctl_t     ctl,
  input  brfee_pkg::item_t    item,
  output brfee_pkg::result_t  result
);
  import brfee_pkg::*;

  item_t       cur;
  logic [31:0] vis [16];
  logic [31:0] fiq_bank [7];
  logic [31:0] hi_bank [4][2];
  logic [31:0] spsr_bank [5];
  logic [31:0] cpsr;
  logic [31:0] spsr;
  logic        fiq_pending;

  logic [31:0] vis_next [16];
  logic [31:0] fiq_bank_next [7];
  logic [31:0] hi_bank_next [4][2];
  logic [31:0] spsr_bank_next [5];
  logic [31:0] cpsr_next;
  logic [31:0] spsr_next;
  logic        fiq_pending_next;
  result_t     result_next;

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cur <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) vis[i] <= '0;
      for (int i = 0; i < 7; i++) fiq_bank[i] <= '0;
      for (int b = 0; b < 4; b++) begin
        hi_bank[b][0] <= '0;
        hi_bank[b][1] <= '0;
      end
      for (int i = 0; i < 5; i++) spsr_bank[i] <= '0;
      cpsr        <= CPSR_RESET;
      spsr        <= '0;
      fiq_pending <= 1'b0;
    end else if (ctl.execute) begin
      vis         <= vis_next;
      fiq_bank    <= fiq_bank_next;
      hi_bank     <= hi_bank_next;
      spsr_bank   <= spsr_bank_next;
      cpsr        <= cpsr_next;
      spsr        <= spsr_next;
      fiq_pending <= fiq_pending_next;
    end
  end

  always_comb begin
    logic [4:0]  mode;
    logic [2:0]  slot;
    logic [1:0]  hb_sel;
    logic [3:0]  gidx;
    logic        in_fiq_bank;
    logic        in_hi_bank;
    logic        do_exc;
    logic [2:0]  kind;
    logic [4:0]  entry_mode;
    logic [4:0]  swap_mode;
    logic [2:0]  swap_slot;
    logic [1:0]  swap_sel;
    logic [31:0] tmp;
    logic [31:0] prior_cpsr;

    vis_next         = vis;
    fiq_bank_next    = fiq_bank;
    hi_bank_next     = hi_bank;
    spsr_bank_next   = spsr_bank;
    cpsr_next        = cpsr;
    spsr_next        = spsr;
    fiq_pending_next = fiq_pending;
    result_next      = '0;

    mode       = cpsr[4:0];
    slot       = status_slot(mode);
    hb_sel     = 2'(slot - SLOT_SVC);
    gidx       = cur.reg_index[3:0];
    do_exc     = 1'b0;
    kind       = cur.exception_kind;
    prior_cpsr = cpsr;
    swap_mode  = mode;
    swap_slot  = slot;
    swap_sel   = hb_sel;
    tmp        = '0;

    // Where the inactive (user) copy of a general register lives.
    in_fiq_bank = (slot == SLOT_FIQ) && (gidx >= 4'd8) && (gidx <= 4'd14);
    in_hi_bank  = (slot != SLOT_FIQ) && (slot != SLOT_NONE) &&
                  ((gidx == 4'd13) || (gidx == 4'd14));

    unique case (cur.command)
      CMD_READ, CMD_WRITE: begin
        if (cur.reg_index > IDX_SPSR) begin
          result_next.error_flag = 1'b1;
        end else if (cur.command == CMD_READ) begin
          if (cur.reg_index == IDX_CPSR) result_next.read_data = cpsr;
          else if (cur.reg_index == IDX_SPSR) result_next.read_data = spsr;
          else result_next.read_data = vis[gidx];
        end else begin
          if (cur.reg_index == IDX_CPSR) cpsr_next = cur.write_value;
          else if (cur.reg_index == IDX_SPSR) spsr_next = cur.write_value;
          else vis_next[gidx] = cur.write_value;
        end
      end
      CMD_USER_READ, CMD_USER_WRITE: begin
        if (cur.reg_index > IDX_LAST_GPR) begin
          result_next.error_flag = 1'b1;
        end else if (cur.command == CMD_USER_READ) begin
          if (in_fiq_bank) result_next.read_data = fiq_bank[3'(gidx - 4'd8)];
          else if (in_hi_bank) result_next.read_data = hi_bank[hb_sel][~gidx[0]];
          else result_next.read_data = vis[gidx];
        end else begin
          if (in_fiq_bank) fiq_bank_next[3'(gidx - 4'd8)] = cur.write_value;
          else if (in_hi_bank) hi_bank_next[hb_sel][~gidx[0]] = cur.write_value;
          else vis_next[gidx] = cur.write_value;
        end
      end
      CMD_EXCEPTION: begin
        if (kind == EXC_INVALID) result_next.error_flag = 1'b1;
        else do_exc = 1'b1;
      end
      CMD_FIQ_SET: fiq_pending_next = 1'b1;
      CMD_INT_CHECK: begin
        if (fiq_pending && !cpsr[BIT_F]) begin
          do_exc = 1'b1;
          kind   = EXC_FIQ;
        end else if (cur.irq_request && !cpsr[BIT_I]) begin
          do_exc = 1'b1;
          kind   = EXC_IRQ;
        end
      end
      default: ;
    endcase

    entry_mode = vector_mode(kind);

    if (do_exc) begin
      result_next.exception_taken = 1'b1;
      if (kind == EXC_FIQ) fiq_pending_next = 1'b0;
      if (slot != SLOT_NONE) spsr_bank_next[slot] = spsr;
      // Swap the old mode's banks out, then the new mode's banks in.
      for (int p = 0; p < 2; p++) begin
        swap_mode = (p == 0) ? mode : entry_mode;
        swap_slot = status_slot(swap_mode);
        swap_sel  = 2'(swap_slot - SLOT_SVC);
        if (swap_slot == SLOT_FIQ) begin
          for (int i = 0; i < 7; i++) begin
            tmp                = vis_next[8 + i];
            vis_next[8 + i]    = fiq_bank_next[i];
            fiq_bank_next[i]   = tmp;
          end
        end else if (swap_slot != SLOT_NONE) begin
          for (int j = 0; j < 2; j++) begin
            tmp                        = vis_next[13 + j];
            vis_next[13 + j]           = hi_bank_next[swap_sel][j];
            hi_bank_next[swap_sel][j]  = tmp;
          end
        end
      end
      spsr_next    = prior_cpsr;
      vis_next[14] = vis_next[15] + LR_OFFSET;
      cpsr_next    = {prior_cpsr[31:5], entry_mode};
      cpsr_next[BIT_I] = 1'b1;
      if (kind == EXC_FIQ || kind == EXC_RESET) cpsr_next[BIT_F] = 1'b1;
      vis_next[15] = vector_addr(kind);
    end

    result_next.pc_value = vis_next[15];
    result_next.mode_now = cpsr_next[4:0];
  end

endmodule

/* hdl/banked_register_file_exception_entry_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// banked_register_file_exception_entry_core: banked register file top level
// Mode-banked register file with exception entry and interrupt arbitration.
// ---------------------------------------------------------------------------
// Each item beat carries one command: register read or write (R0-R15, CPSR,
// SPSR), read or write of the user-mode copy of a register, exception entry,
// FIQ latch, or an interrupt check where FIQ wins over IRQ. Every item gives
// exactly one result beat with the read data, whether an exception was taken,
// the new PC, the new mode bits and an error flag for a bad register index or
// exception kind (an erroneous command changes nothing). An item is first
// captured from its beat and then executed: the datapath applies the whole
// command, bank swaps of an exception entry included, and writes the result
// register. The sequencer serves one item at a time and takes no new beat
// until the last item has executed. The result register decouples the two
// sides: the next item beat is taken while a result still waits, and only the
// execute cycle stalls while that result stays untaken.
// ---------------------------------------------------------------------------
module banked_register_file_exception_entry_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  brfee_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_ready,
  output brfee_pkg::result_t  result
);
  import brfee_pkg::*;

  ctl_t ctl;

  // The sequencer owns the handshakes and strobes the datapath.
  brfee_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .ctl          (ctl)
  );

  // The datapath holds all architectural state and the result register.
  brfee_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (item),
    .result (result)
  );

endmodule

/* tb/sv/banked_register_file_exception_entry_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// banked_register_file_exception_entry_checker: result checker
// Watches both channels, keeps its own copy of the banked register state,
// works out the result of every accepted command and compares each result
// beat with it.
// ---------------------------------------------------------------------------
module banked_register_file_exception_entry_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  brfee_pkg::item_t    item,
  input  logic                result_valid,
  input  logic                result_ready,
  input  brfee_pkg::result_t  result,
  output int unsigned         failures,
  output int unsigned         pending
);
  import brfee_pkg::*;

  localparam int FIQ_FIRST  = 8;
  localparam int BANK_FIRST = 13;
  localparam int LR_REG     = 14;
  localparam int PC_REG     = 15;

  logic [31:0] gpr [16];
  logic [31:0] fiq_copy [8:14];
  logic [31:0] svc_copy [13:14];
  logic [31:0] abt_copy [13:14];
  logic [31:0] irq_copy [13:14];
  logic [31:0] und_copy [13:14];
  logic [31:0] spsr_saved [5];
  logic [31:0] cpsr;
  logic [31:0] spsr;
  logic        fiq_latched;

  result_t     pending_results [$];
  int unsigned mismatches;

  function automatic void clear_registers();
    for (int i = 0; i < 16; i++) gpr[i] = '0;
    for (int i = 8; i <= 14; i++) fiq_copy[i] = '0;
    for (int i = 13; i <= 14; i++) begin
      svc_copy[i] = '0;
      abt_copy[i] = '0;
      irq_copy[i] = '0;
      und_copy[i] = '0;
    end
    for (int i = 0; i < 5; i++) spsr_saved[i] = '0;
    cpsr        = CPSR_RESET;
    spsr        = '0;
    fiq_latched = 1'b0;
  endfunction

  // True when the mode keeps a private copy of register idx.
  function automatic bit has_private_copy(input logic [4:0] mode, input int idx);
    if (mode == PM_FIQ) return idx >= FIQ_FIRST && idx <= LR_REG;
    if (idx < BANK_FIRST || idx > LR_REG) return 1'b0;
    case (mode)
      PM_SVC, PM_ABT, PM_IRQ, PM_UND: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [31:0] shadow_read(input logic [4:0] mode, input int idx);
    case (mode)
      PM_FIQ:  return fiq_copy[idx];
      PM_SVC:  return svc_copy[idx];
      PM_ABT:  return abt_copy[idx];
      PM_IRQ:  return irq_copy[idx];
      PM_UND:  return und_copy[idx];
      default: return gpr[idx];
    endcase
  endfunction

  function automatic void shadow_write(input logic [4:0] mode, input int idx,
                                       input logic [31:0] value);
    case (mode)
      PM_FIQ:  fiq_copy[idx] = value;
      PM_SVC:  svc_copy[idx] = value;
      PM_ABT:  abt_copy[idx] = value;
      PM_IRQ:  irq_copy[idx] = value;
      PM_UND:  und_copy[idx] = value;
      default: gpr[idx] = value;
    endcase
  endfunction

  function automatic int spsr_slot(input logic [4:0] mode);
    case (mode)
      PM_FIQ:  return int'(SLOT_FIQ);
      PM_SVC:  return int'(SLOT_SVC);
      PM_ABT:  return int'(SLOT_ABT);
      PM_IRQ:  return int'(SLOT_IRQ);
      PM_UND:  return int'(SLOT_UND);
      default: return -1;
    endcase
  endfunction

  function automatic void exchange_bank(input logic [4:0] mode);
    logic [31:0] held;
    for (int i = FIQ_FIRST; i <= LR_REG; i++) begin
      if (has_private_copy(mode, i)) begin
        held   = gpr[i];
        gpr[i] = shadow_read(mode, i);
        shadow_write(mode, i, held);
      end
    end
  endfunction

  function automatic logic [4:0] exception_mode(input logic [2:0] kind);
    case (kind)
      EXC_UNDEF:          return PM_UND;
      EXC_PABT, EXC_DABT: return PM_ABT;
      EXC_IRQ:            return PM_IRQ;
      EXC_FIQ:            return PM_FIQ;
      default:            return PM_SVC;
    endcase
  endfunction

  function automatic void take_exception(input logic [2:0] kind);
    logic [31:0] prior_cpsr;
    logic [4:0]  entry_mode;
    int          slot;
    prior_cpsr = cpsr;
    entry_mode = exception_mode(kind);
    if (kind == EXC_FIQ) fiq_latched = 1'b0;
    // Put the old mode's copies away, then bring in the new mode's.
    exchange_bank(prior_cpsr[4:0]);
    slot = spsr_slot(prior_cpsr[4:0]);
    if (slot >= 0) spsr_saved[slot] = spsr;
    exchange_bank(entry_mode);
    slot = spsr_slot(entry_mode);
    if (slot >= 0) spsr = spsr_saved[slot];
    spsr        = prior_cpsr;
    gpr[LR_REG] = gpr[PC_REG] + LR_OFFSET;
    cpsr[4:0]   = entry_mode;
    cpsr[BIT_I] = 1'b1;
    if (kind == EXC_FIQ || kind == EXC_RESET) cpsr[BIT_F] = 1'b1;
    // Vectors step by four, with one word skipped before IRQ.
    gpr[PC_REG] = {27'd0, kind, 2'b00} + ((kind >= EXC_IRQ) ? 32'd4 : 32'd0);
  endfunction

  function automatic result_t run_command(input item_t beat);
    result_t    r;
    logic [4:0] mode;
    int         idx;
    r    = '0;
    mode = cpsr[4:0];
    idx  = int'(beat.reg_index);
    case (beat.command)
      CMD_READ, CMD_WRITE: begin
        if (beat.reg_index > IDX_SPSR) begin
          r.error_flag = 1'b1;
        end else if (beat.command == CMD_READ) begin
          if (beat.reg_index == IDX_CPSR) r.read_data = cpsr;
          else if (beat.reg_index == IDX_SPSR) r.read_data = spsr;
          else r.read_data = gpr[idx];
        end else begin
          if (beat.reg_index == IDX_CPSR) cpsr = beat.write_value;
          else if (beat.reg_index == IDX_SPSR) spsr = beat.write_value;
          else gpr[idx] = beat.write_value;
        end
      end
      CMD_USER_READ, CMD_USER_WRITE: begin
        if (beat.reg_index > IDX_LAST_GPR) begin
          r.error_flag = 1'b1;
        end else if (has_private_copy(mode, idx)) begin
          if (beat.command == CMD_USER_READ) r.read_data = shadow_read(mode, idx);
          else shadow_write(mode, idx, beat.write_value);
        end else begin
          if (beat.command == CMD_USER_READ) r.read_data = gpr[idx];
          else gpr[idx] = beat.write_value;
        end
      end
      CMD_EXCEPTION: begin
        if (beat.exception_kind == EXC_INVALID) begin
          r.error_flag = 1'b1;
        end else begin
          take_exception(beat.exception_kind);
          r.exception_taken = 1'b1;
        end
      end
      CMD_FIQ_SET: fiq_latched = 1'b1;
      CMD_INT_CHECK: begin
        if (fiq_latched && !cpsr[BIT_F]) begin
          take_exception(EXC_FIQ);
          r.exception_taken = 1'b1;
        end else if (beat.irq_request && !cpsr[BIT_I]) begin
          take_exception(EXC_IRQ);
          r.exception_taken = 1'b1;
        end
      end
      default: ;
    endcase
    r.pc_value = gpr[PC_REG];
    r.mode_now = cpsr[4:0];
    return r;
  endfunction

  // The result side is handled before the item side, so a result beat is
  // always matched against commands accepted at earlier edges.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_registers();
      pending_results.delete();
      mismatches = 0;
      failures <= 0;
      pending  <= 0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with no command outstanding: pc=%h mode=%h",
                     $realtime, result.pc_value, result.mode_now);
        end else begin
          want = pending_results.pop_front();
          if (result.read_data !== want.read_data ||
              result.exception_taken !== want.exception_taken ||
              result.pc_value !== want.pc_value ||
              result.mode_now !== want.mode_now ||
              result.error_flag !== want.error_flag) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected rd=%h exc=%b pc=%h mode=%h err=%b",
                       want.read_data, want.exception_taken, want.pc_value,
                       want.mode_now, want.error_flag);
              $display("  got      rd=%h exc=%b pc=%h mode=%h err=%b",
                       result.read_data, result.exception_taken, result.pc_value,
                       result.mode_now, result.error_flag);
            end
          end
        end
      end
      if (item_valid && item_ready) pending_results.push_back(run_command(item));
      failures <= mismatches;
      pending  <= pending_results.size();
    end
  end

endmodule

/* tb/sv/banked_register_file_exception_entry_core_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// banked_register_file_exception_entry_core_test: top-level testbench
// Drives command beats into the banked register file, takes result beats
// with random stalls, and reports the verdict of the result checker.
// ---------------------------------------------------------------------------
module banked_register_file_exception_entry_core_test;
  import brfee_pkg::*;

  // Command code the block must ignore without raising an error.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // Register numbers used by the directed sequence.
  localparam logic [4:0] GPR_R0    = 5'd0;
  localparam logic [4:0] GPR_R8    = 5'd8;
  localparam logic [4:0] GPR_SP    = 5'd13;
  localparam logic [4:0] GPR_PC    = 5'd15;
  localparam logic [4:0] INDEX_MAX = 5'd31;

  localparam int          RANDOM_BEATS = 900;
  localparam int          HOLD_CYCLES  = 80;
  localparam int unsigned CYCLE_LIMIT  = 100000;

  logic        clk;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  item_t       item_beat    = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result_beat;
  int unsigned failures;
  int unsigned pending;

  // Handshake between the sender and the receiver processes. While calm is
  // set neither side idles; hold_request asks the receiver for one long
  // hold-off, and holding tells the sender to keep offering without gaps.
  bit          calm         = 1'b0;
  bit          hold_request = 1'b0;
  bit          holding      = 1'b0;
  int unsigned cycle_count  = 0;

  banked_register_file_exception_entry_core uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_beat)
  );

  banked_register_file_exception_entry_checker checker_inst (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_beat),
    .failures     (failures),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Guard against a hung handshake anywhere in the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic item_t make_beat(input logic [2:0] cmd, input logic [4:0] idx,
                                      input logic [31:0] value, input logic [2:0] kind,
                                      input logic irq);
    item_t b;
    b.command        = cmd;
    b.reg_index      = idx;
    b.write_value    = value;
    b.exception_kind = kind;
    b.irq_request    = irq;
    return b;
  endfunction

  // A status word whose mode field is usually one of the banked modes or
  // user mode, so status writes keep moving the block between banks. The
  // I and F masks and the upper bits stay random.
  function automatic logic [31:0] random_status();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 7))
      0: v[4:0] = PM_USER;
      1: v[4:0] = PM_FIQ;
      2: v[4:0] = PM_IRQ;
      3: v[4:0] = PM_SVC;
      4: v[4:0] = PM_ABT;
      5: v[4:0] = PM_UND;
      default: ;
    endcase
    return v;
  endfunction

  // Mostly well-formed commands, with a tail of bad indexes, invalid
  // exception kinds and the unused command code.
  function automatic item_t random_beat();
    item_t b;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 22)      b.command = CMD_READ;
    else if (pick < 44) b.command = CMD_WRITE;
    else if (pick < 54) b.command = CMD_USER_READ;
    else if (pick < 64) b.command = CMD_USER_WRITE;
    else if (pick < 74) b.command = CMD_EXCEPTION;
    else if (pick < 82) b.command = CMD_FIQ_SET;
    else if (pick < 95) b.command = CMD_INT_CHECK;
    else                b.command = CMD_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 80)      b.reg_index = 5'($urandom_range(0, int'(IDX_LAST_GPR)));
    else if (pick < 92) b.reg_index = 5'($urandom_range(int'(IDX_CPSR), int'(IDX_SPSR)));
    else                b.reg_index = 5'($urandom_range(int'(IDX_SPSR) + 1, int'(INDEX_MAX)));
    if (b.command == CMD_WRITE && b.reg_index == IDX_CPSR) b.write_value = random_status();
    else b.write_value = $urandom();
    if ($urandom_range(0, 99) < 90)
      b.exception_kind = 3'($urandom_range(int'(EXC_RESET), int'(EXC_FIQ)));
    else
      b.exception_kind = EXC_INVALID;
    b.irq_request = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // Offer one beat and return at the edge where it is accepted. Valid stays
  // high on return so back-to-back beats need no second assignment.
  task automatic offer_beat(input item_t beat);
    int gap;
    gap = 0;
    if (!calm && !holding && $urandom_range(0, 99) < 33) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_beat  <= beat;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every result beat owed has come back.
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: random stalls, no stalls during the calm window, and one long
  // hold-off so the block fills up and has to stall its item side.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_request && !holding) begin
        holding       = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request  = 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(0, 99) >= 33);
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The status word comes out of reset as supervisor mode
    // with both interrupts masked.
    offer_beat(make_beat(CMD_READ, IDX_CPSR, '0, EXC_RESET, 1'b0));
    // A PC near the top of the address space makes the link value wrap.
    offer_beat(make_beat(CMD_WRITE, GPR_PC, 32'hFFFF_FFFC, EXC_RESET, 1'b0));
    offer_beat(make_beat(CMD_WRITE, GPR_R0, 32'hFFFF_FFFF, EXC_INVALID, 1'b1));
    offer_beat(make_beat(CMD_READ, GPR_R0, '0, EXC_RESET, 1'b0));
    // Supervisor SP versus the user copy sitting in the bank.
    offer_beat(make_beat(CMD_WRITE, GPR_SP, 32'h1357_9BDF, EXC_RESET, 1'b0));
    offer_beat(make_beat(CMD_USER_WRITE, GPR_SP, 32'h2468_ACE0, EXC_RESET, 1'b0));
    offer_beat(make_beat(CMD_USER_READ, GPR_SP, '0, EXC_RESET, 1'b0));
    offer_beat(make_beat(CMD_READ, GPR_SP, '0, EXC_RESET, 1'b0));
    // Bad register indexes must flag an error and change nothing.
    offer_beat(make_beat(CMD_READ, INDEX_MAX, '0, EXC_RESET, 1'b0));
    offer_beat(make_beat(CMD_USER_READ, IDX_CPSR, '0, EXC_RESET, 1'b0));
    offer_beat(make_beat(CMD_WRITE, IDX_SPSR + 5'd1, 32'hDEAD_BEEF, EXC_RESET, 1'b0));
    offer_beat(make_beat(CMD_EXCEPTION, GPR_R0, '0, EXC_INVALID, 1'b0));
    // Every exception kind, each entered from the previous one's mode.
    for (int k = int'(EXC_RESET); k <= int'(EXC_FIQ); k++)
      offer_beat(make_beat(CMD_EXCEPTION, GPR_R0, '0, 3'(k), 1'b0));
    // FIQ latched while masked: the check takes nothing, then FIQ wins over
    // IRQ once user mode with both masks clear is set.
    offer_beat(make_beat(CMD_FIQ_SET, GPR_R0, '0, EXC_RESET, 1'b0));
    offer_beat(make_beat(CMD_INT_CHECK, GPR_R0, '0, EXC_RESET, 1'b1));
    offer_beat(make_beat(CMD_WRITE, IDX_CPSR, {27'd0, PM_USER}, EXC_RESET, 1'b0));
    offer_beat(make_beat(CMD_INT_CHECK, GPR_R0, '0, EXC_RESET, 1'b1));
    offer_beat(make_beat(CMD_USER_READ, GPR_R8, '0, EXC_RESET, 1'b0));
    offer_beat(make_beat(CMD_UNUSED, GPR_R0, '0, EXC_RESET, 1'b0));
    // A mode with no banks behaves as user mode for the user view.
    offer_beat(make_beat(CMD_WRITE, IDX_CPSR, 32'hFFFF_FFFF, EXC_RESET, 1'b0));
    offer_beat(make_beat(CMD_USER_READ, GPR_SP, '0, EXC_RESET, 1'b0));

    // The sender pauses here until every result beat has come back.
    wait_drained();

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      calm = (n >= 200 && n < 350);
      if (n == 500) hold_request = 1'b1;
      if (holding && !hold_request) holding = 1'b0;
      offer_beat(random_beat());
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* banked_register_file_exception_entry_core.f */
hdl/brfee_pkg.sv
hdl/brfee_ctrl.sv
hdl/brfee_datapath.sv
hdl/banked_register_file_exception_entry_core.sv
tb/sv/banked_register_file_exception_entry_checker.sv
tb/sv/banked_register_file_exception_entry_core_test.sv
